### rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the free-list allocator
// Holds the page constants, states, operations, decision codes, status group and result codes.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam logic [31:0] PAGE_ROUND = 32'h0000_0fff;
    localparam logic [31:0] PAGE_MASK  = 32'hffff_f000;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_LOST  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CK, S_DEC, S_DN_RD, S_DN_WR, S_UP_RD, S_UP_WR, S_INS, S_FIN
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_READ, OP_CHECK, OP_NOFIT, OP_DECIDE,
        OP_DN_RD, OP_DN_WR, OP_SHRINK, OP_UP_RD, OP_UP_WR, OP_INSERT, OP_FINISH
    } t_op;

    typedef enum logic [1:0] {
        DEC_DONE, DEC_REMOVE, DEC_INSERT
    } t_dec;

    typedef struct packed {
        logic is_free;
        logic at_end;
        logic ck_hit;
        logic ck_zero;
        t_dec dec;
        logic dn_end;
        logic up_end;
        logic out_free;
    } t_stat;

endpackage

### rtl/ffa_req_if.sv
// ----------------------------------------------------------------------------
// ffa_req_if: request channel
// Valid/ready channel carrying one allocate or free transaction.
// ----------------------------------------------------------------------------
interface ffa_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] region_address;
    logic [31:0] request_size;
    logic        round_to_page;

    modport source (output valid, cmd, region_address, request_size, round_to_page,
                    input ready);
    modport sink   (input valid, cmd, region_address, request_size, round_to_page,
                    output ready);
endinterface

### rtl/ffa_rsp_if.sv
// ----------------------------------------------------------------------------
// ffa_rsp_if: result channel
// Valid/ready channel carrying one result transaction per request.
// ----------------------------------------------------------------------------
interface ffa_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] alloc_address;
    logic [1:0]  status;
    logic [12:0] entries_in_use;
    logic [12:0] peak_entries;
    logic [31:0] lost_frees;
    logic [31:0] lost_bytes;
    logic [31:0] free_bytes_total;

    modport source (output valid, alloc_address, status, entries_in_use, peak_entries,
                    lost_frees, lost_bytes, free_bytes_total, input ready);
    modport sink   (input valid, alloc_address, status, entries_in_use, peak_entries,
                    lost_frees, lost_bytes, free_bytes_total, output ready);
endinterface

### rtl/first_fit_free_list_allocator_unit.sv
// Sequence: a request scans the region table, then shifts table entries up or down,
// and then waits for a free result register before its result is made valid.
// Throughput: one request at a time; the transaction time is set by the single read
// port of the region table, through which every scanned or shifted entry is read in turn.
// Reset: synchronous, active low; clears the counters and the sequencer, the table
// itself is not cleared since only entries below the entry count are ever read.
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_unit: first-fit free-list allocator
// Keeps address-sorted free regions, allocates first fit and coalesces frees.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_unit
    import ffa_pkg::*;
#(
    parameter int ENTRIES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffa_req_if.sink    i_req,
    ffa_rsp_if.source  o_rsp
);
    // The sequencer issues at most one datapath operation per cycle and reacts to the
    // status group that the datapath returns.
    t_op   w_op;
    t_stat w_stat;

    ffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (w_stat),
        .o_op       (w_op)
    );

    // The datapath owns the region table, the running totals and the result
    // register; a finished result waits there while the next transaction is taken.
    ffa_dp #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_op               (w_op),
        .o_stat             (w_stat),
        .i_cmd              (i_req.cmd),
        .i_region_address   (i_req.region_address),
        .i_request_size     (i_req.request_size),
        .i_round_to_page    (i_req.round_to_page),
        .i_out_ready        (o_rsp.ready),
        .o_out_valid        (o_rsp.valid),
        .o_alloc_address    (o_rsp.alloc_address),
        .o_status           (o_rsp.status),
        .o_entries_in_use   (o_rsp.entries_in_use),
        .o_peak_entries     (o_rsp.peak_entries),
        .o_lost_frees       (o_rsp.lost_frees),
        .o_lost_bytes       (o_rsp.lost_bytes),
        .o_free_bytes_total (o_rsp.free_bytes_total)
    );

`ifndef SYNTHESIS
    // A failed allocate never hands out an address.
    a_nofit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_NOFIT) |-> (o_rsp.alloc_address == 32'd0))
        else $error("failed allocate returned a nonzero address");

    // After a transaction is accepted the unit is not ready again in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while previous one still in progress");

    // The reported peak never trails the current entry count.
    a_peak_ge_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.peak_entries >= o_rsp.entries_in_use))
        else $error("peak entry count below current entry count");

    // Only a free can be lost.
    a_lost_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == OP_DECIDE) |-> w_stat.is_free)
        else $error("insert decision taken for an allocate");
`endif
endmodule

### rtl/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl: allocator sequencer
// Walks each request through scan, decision, shift and result steps.
// ----------------------------------------------------------------------------
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_op   o_op
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (i_stat.at_end) begin
                    if (i_stat.is_free) begin
                        n_state = S_DEC;
                    end else begin
                        o_op    = OP_NOFIT;
                        n_state = S_FIN;
                    end
                end else begin
                    o_op    = OP_READ;
                    n_state = S_CK;
                end
            end
            S_CK: begin
                o_op = OP_CHECK;
                if (!i_stat.ck_hit) begin
                    n_state = S_RD;
                end else if (i_stat.is_free) begin
                    n_state = S_DEC;
                end else if (i_stat.ck_zero) begin
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DEC: begin
                o_op = OP_DECIDE;
                case (i_stat.dec)
                    DEC_REMOVE: n_state = S_DN_RD;
                    DEC_INSERT: n_state = S_UP_RD;
                    default:    n_state = S_FIN;
                endcase
            end
            S_DN_RD: begin
                if (i_stat.dn_end) begin
                    o_op    = OP_SHRINK;
                    n_state = S_FIN;
                end else begin
                    o_op    = OP_DN_RD;
                    n_state = S_DN_WR;
                end
            end
            S_DN_WR: begin
                o_op    = OP_DN_WR;
                n_state = S_DN_RD;
            end
            S_UP_RD: begin
                if (i_stat.up_end) begin
                    n_state = S_INS;
                end else begin
                    o_op    = OP_UP_RD;
                    n_state = S_UP_WR;
                end
            end
            S_UP_WR: begin
                o_op    = OP_UP_WR;
                n_state = S_UP_RD;
            end
            S_INS: begin
                o_op    = OP_INSERT;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_op    = OP_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

### rtl/ffa_dp.sv
// ----------------------------------------------------------------------------
// ffa_dp: allocator datapath
// Region table, scan registers, running counters and the result register.
// ----------------------------------------------------------------------------
module ffa_dp
    import ffa_pkg::*;
#(
    parameter int ENTRIES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    output t_stat       o_stat,
    input  logic        i_cmd,
    input  logic [31:0] i_region_address,
    input  logic [31:0] i_request_size,
    input  logic        i_round_to_page,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [31:0] o_alloc_address,
    output logic [1:0]  o_status,
    output logic [12:0] o_entries_in_use,
    output logic [12:0] o_peak_entries,
    output logic [31:0] o_lost_frees,
    output logic [31:0] o_lost_bytes,
    output logic [31:0] o_free_bytes_total
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [CW-1:0] r_cnt, r_peak, r_idx, r_j;
    logic [31:0]   r_lost, r_lsum, r_fsum;
    logic          r_ovalid;
    logic          r_is_free, r_prev_v;
    logic [31:0]   r_addr, r_size, r_aend, r_given;
    logic [31:0]   r_prev_s, r_prev_l, r_prev_end, r_cur_s, r_cur_l;
    logic [1:0]    r_status;
    logic [31:0]   r_o_addr, r_o_lost, r_o_lsum, r_o_fsum;
    logic [1:0]    r_o_status;
    logic [12:0]   r_o_cnt, r_o_peak;

    logic          w_we, w_re;
    logic [IW-1:0] w_waddr, w_raddr;
    logic [63:0]   w_wdata, w_rdata;
    logic [31:0]   w_rstart, w_rlen, w_rsize, w_newlen;
    logic [IW-1:0] w_idx_lo, w_idx_m1, w_j_lo, w_j_m1;
    logic          w_fit, w_stop, w_mprev, w_mnext, w_room;
    logic [CW-1:0] w_cnt_p1;

    assign w_rstart = w_rdata[63:32];
    assign w_rlen   = w_rdata[31:0];
    assign w_rsize  = i_round_to_page ? ((i_request_size + PAGE_ROUND) & PAGE_MASK)
                                      : i_request_size;
    assign w_newlen = w_rlen - r_size;
    assign w_fit    = (w_rlen >= r_size);
    assign w_stop   = (w_rstart > r_addr);
    assign w_idx_lo = r_idx[IW-1:0];
    assign w_idx_m1 = IW'(r_idx - CW'(1));
    assign w_j_lo   = r_j[IW-1:0];
    assign w_j_m1   = IW'(r_j - CW'(1));
    assign w_mprev  = r_prev_v && (r_prev_end == r_addr);
    assign w_mnext  = (r_idx != r_cnt) && (r_aend == r_cur_s);
    assign w_room   = (r_cnt < CW'(ENTRIES));
    assign w_cnt_p1 = r_cnt + CW'(1);

    always_comb begin
        o_stat.is_free  = r_is_free;
        o_stat.at_end   = (r_idx == r_cnt);
        o_stat.ck_hit   = r_is_free ? w_stop : w_fit;
        o_stat.ck_zero  = (w_newlen == 32'd0);
        o_stat.dn_end   = (r_j == r_cnt);
        o_stat.up_end   = (r_j == r_idx);
        o_stat.out_free = !r_ovalid || i_out_ready;
        if (w_mprev && w_mnext) begin
            o_stat.dec = DEC_REMOVE;
        end else if (!w_mprev && !w_mnext && w_room) begin
            o_stat.dec = DEC_INSERT;
        end else begin
            o_stat.dec = DEC_DONE;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = w_idx_lo;
        w_raddr = w_idx_lo;
        w_wdata = w_rdata;
        case (i_op)
            OP_READ: w_re = 1'b1;
            OP_CHECK: begin
                w_we    = !r_is_free && w_fit && (w_newlen != 32'd0);
                w_wdata = {w_rstart + r_size, w_newlen};
            end
            OP_DECIDE: begin
                if (w_mprev) begin
                    w_we    = 1'b1;
                    w_waddr = w_idx_m1;
                    w_wdata = {r_prev_s, r_prev_l + r_size + (w_mnext ? r_cur_l : 32'd0)};
                end else if (w_mnext) begin
                    w_we    = 1'b1;
                    w_wdata = {r_addr, r_cur_l + r_size};
                end
            end
            OP_DN_RD: begin
                w_re    = 1'b1;
                w_raddr = w_j_lo;
            end
            OP_DN_WR: begin
                w_we    = 1'b1;
                w_waddr = w_j_m1;
            end
            OP_UP_RD: begin
                w_re    = 1'b1;
                w_raddr = w_j_m1;
            end
            OP_UP_WR: begin
                w_we    = 1'b1;
                w_waddr = w_j_lo;
            end
            OP_INSERT: begin
                w_we    = 1'b1;
                w_wdata = {r_addr, r_size};
            end
            default: ;
        endcase
    end

    ffa_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Counters and the result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_peak   <= '0;
            r_lost   <= '0;
            r_lsum   <= '0;
            r_fsum   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_op)
                OP_CHECK: begin
                    if (!r_is_free && w_fit) begin
                        r_fsum <= r_fsum - r_size;
                    end
                end
                OP_DECIDE: begin
                    if (w_mprev || w_mnext) begin
                        r_fsum <= r_fsum + r_size;
                    end else if (!w_room) begin
                        r_lost <= r_lost + 32'd1;
                        r_lsum <= r_lsum + r_size;
                    end
                end
                OP_SHRINK: r_cnt <= r_cnt - CW'(1);
                OP_INSERT: begin
                    r_cnt  <= w_cnt_p1;
                    r_fsum <= r_fsum + r_size;
                    if (r_peak < w_cnt_p1) begin
                        r_peak <= w_cnt_p1;
                    end
                end
                OP_FINISH: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    // Working registers of the request in flight and the result payload.
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_is_free <= i_cmd;
                r_addr    <= i_region_address;
                r_size    <= w_rsize;
                r_aend    <= i_region_address + w_rsize;
                r_idx     <= '0;
                r_prev_v  <= 1'b0;
                r_given   <= '0;
                r_status  <= ST_OK;
            end
            OP_NOFIT: r_status <= ST_NOFIT;
            OP_CHECK: begin
                if (r_is_free) begin
                    if (w_stop) begin
                        r_cur_s <= w_rstart;
                        r_cur_l <= w_rlen;
                    end else begin
                        r_prev_s   <= w_rstart;
                        r_prev_l   <= w_rlen;
                        r_prev_end <= w_rstart + w_rlen;
                        r_prev_v   <= 1'b1;
                        r_idx      <= r_idx + CW'(1);
                    end
                end else if (w_fit) begin
                    r_given <= w_rstart;
                    r_j     <= r_idx + CW'(1);
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            OP_DECIDE: begin
                if (w_mprev || w_mnext) begin
                    r_j <= r_idx + CW'(1);
                end else if (w_room) begin
                    r_j <= r_cnt;
                end else begin
                    r_status <= ST_LOST;
                end
            end
            OP_DN_WR: r_j <= r_j + CW'(1);
            OP_UP_WR: r_j <= r_j - CW'(1);
            OP_FINISH: begin
                r_o_addr   <= r_given;
                r_o_status <= r_status;
                r_o_cnt    <= 13'(r_cnt);
                r_o_peak   <= 13'(r_peak);
                r_o_lost   <= r_lost;
                r_o_lsum   <= r_lsum;
                r_o_fsum   <= r_fsum;
            end
            default: ;
        endcase
    end

    assign o_out_valid        = r_ovalid;
    assign o_alloc_address    = r_o_addr;
    assign o_status           = r_o_status;
    assign o_entries_in_use   = r_o_cnt;
    assign o_peak_entries     = r_o_peak;
    assign o_lost_frees       = r_o_lost;
    assign o_lost_bytes       = r_o_lsum;
    assign o_free_bytes_total = r_o_fsum;
endmodule

### bench/ffa_tb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffa_tb_if: bench-side view of the allocator channels
// The channel interfaces come with the RTL; this file only groups the bench's
// own record types used by the driver and the monitor.
// ----------------------------------------------------------------------------
package ffa_tb_pkg;

    typedef struct {
        logic        cmd;
        logic [31:0] region_address;
        logic [31:0] request_size;
        logic        round_to_page;
    } t_request;

    typedef struct {
        logic [31:0] alloc_address;
        logic [1:0]  status;
        logic [12:0] entries_in_use;
        logic [12:0] peak_entries;
        logic [31:0] lost_frees;
        logic [31:0] lost_bytes;
        logic [31:0] free_bytes_total;
    } t_result;

endpackage

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: bench for the first-fit free-list allocator
// Drives allocate and free transactions with random gaps, predicts every
// result with a behavioral free-region table and checks each field.
// ----------------------------------------------------------------------------
module tb_top;
    import ffa_pkg::*;
    import ffa_tb_pkg::*;

    localparam int TABLE_DEPTH = 4096;
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    logic i_clk;
    logic i_rst_n;

    ffa_req_if req_ch ();
    ffa_rsp_if rsp_ch ();

    first_fit_free_list_allocator_unit #(.ENTRIES(TABLE_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predicted free-region table, kept sorted by start address.
    logic [31:0] free_start [$];
    logic [31:0] free_len   [$];
    logic [31:0] peak_seen, lost_cnt, lost_sum, free_sum;

    t_request pending_reqs [$];
    t_result  expected_results [$];
    int       error_count;
    bit       stim_done;
    int       hold_off;          // cycles of forced receiver stall
    int       n_offered;         // transactions put on the request channel
    int       n_taken;           // transactions accepted by the block

    // Model one request and return the result the block must produce.
    function automatic t_result predict_request(t_request r);
        t_result     res;
        logic [31:0] sz;
        int          i;
        bit          done;
        sz = r.request_size;
        done = 0;
        if (r.round_to_page) sz = (sz + PAGE_ROUND) & PAGE_MASK;
        res.alloc_address = '0;
        res.status = ST_OK;
        if (r.cmd == CMD_ALLOC) begin
            res.status = ST_NOFIT;
            for (i = 0; i < free_start.size() && !done; i++) begin
                if (free_len[i] >= sz) begin
                    res.alloc_address = free_start[i];
                    res.status = ST_OK;
                    free_start[i] += sz;
                    free_len[i] -= sz;
                    free_sum -= sz;
                    if (free_len[i] == 0) begin
                        free_start.delete(i);
                        free_len.delete(i);
                    end
                    done = 1;
                end
            end
        end else begin
            // Find the first entry starting above the freed address.
            i = 0;
            while (i < free_start.size() && free_start[i] <= r.region_address) i++;
            if (i > 0 && free_start[i-1] + free_len[i-1] == r.region_address) begin
                // Merge into the lower neighbor, then maybe absorb the upper one.
                free_len[i-1] += sz;
                free_sum += sz;
                if (i < free_start.size() && r.region_address + sz == free_start[i]) begin
                    free_len[i-1] += free_len[i];
                    free_start.delete(i);
                    free_len.delete(i);
                end
            end else if (i < free_start.size() && r.region_address + sz == free_start[i]) begin
                free_start[i] = r.region_address;
                free_len[i] += sz;
                free_sum += sz;
            end else if (free_start.size() < TABLE_DEPTH) begin
                free_start.insert(i, r.region_address);
                free_len.insert(i, sz);
                free_sum += sz;
                if (peak_seen < free_start.size()) peak_seen = free_start.size();
            end else begin
                res.status = ST_LOST;
                lost_cnt++;
                lost_sum += sz;
            end
        end
        res.entries_in_use = 13'(free_start.size());
        res.peak_entries = 13'(peak_seen);
        res.lost_frees = lost_cnt;
        res.lost_bytes = lost_sum;
        res.free_bytes_total = free_sum;
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", field, got, want);
        error_count++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: valid stays high until the offered transaction has been taken.
    int drive_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || n_taken == n_offered) begin
            // The offered transaction (if any) was accepted at an earlier edge.
            if (req_ch.valid) begin
                drive_gap = pick_gap();
            end
            if (drive_gap > 0) begin
                drive_gap--;
                req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                req_ch.valid          <= 1'b1;
                req_ch.cmd            <= pending_reqs[0].cmd;
                req_ch.region_address <= pending_reqs[0].region_address;
                req_ch.request_size   <= pending_reqs[0].request_size;
                req_ch.round_to_page  <= pending_reqs[0].round_to_page;
                n_offered++;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Prediction happens at acceptance, in order.
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            expected_results.push_back(predict_request(pending_reqs.pop_front()));
            n_taken++;
        end
    end

    // Receiver stall pattern, with an occasional long hold-off.
    int sink_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            sink_gap = 0;
        end else if (hold_off > 0) begin
            hold_off--;
            rsp_ch.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) sink_gap = pick_gap();
        end
    end

    // Monitor: compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", rsp_ch.alloc_address, 32'd0);
            end else begin
                w = expected_results.pop_front();
                if (rsp_ch.alloc_address !== w.alloc_address)
                    report_mismatch("alloc_address", rsp_ch.alloc_address, w.alloc_address);
                if (rsp_ch.status !== w.status)
                    report_mismatch("status", 32'(rsp_ch.status), 32'(w.status));
                if (rsp_ch.entries_in_use !== w.entries_in_use)
                    report_mismatch("entries_in_use", 32'(rsp_ch.entries_in_use),
                                    32'(w.entries_in_use));
                if (rsp_ch.peak_entries !== w.peak_entries)
                    report_mismatch("peak_entries", 32'(rsp_ch.peak_entries),
                                    32'(w.peak_entries));
                if (rsp_ch.lost_frees !== w.lost_frees)
                    report_mismatch("lost_frees", rsp_ch.lost_frees, w.lost_frees);
                if (rsp_ch.lost_bytes !== w.lost_bytes)
                    report_mismatch("lost_bytes", rsp_ch.lost_bytes, w.lost_bytes);
                if (rsp_ch.free_bytes_total !== w.free_bytes_total)
                    report_mismatch("free_bytes_total", rsp_ch.free_bytes_total,
                                    w.free_bytes_total);
            end
        end
    end

    function automatic t_request make_req(logic c, logic [31:0] a, logic [31:0] s, logic rnd);
        t_request r;
        r.cmd = c;
        r.region_address = a;
        r.request_size = s;
        r.round_to_page = rnd;
        return r;
    endfunction

    // Stimulus. Addresses of random frees come mostly from a small window so
    // that merges with both neighbors happen often.
    initial begin
        int          n;
        logic [31:0] a, s;
        error_count = 0;
        stim_done = 0;
        hold_off = 0;
        drive_gap = 0;
        n_offered = 0;
        n_taken = 0;
        peak_seen = 0;
        lost_cnt = 0;
        lost_sum = 0;
        free_sum = 0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_ALLOC;
        req_ch.region_address = '0;
        req_ch.request_size = '0;
        req_ch.round_to_page = 1'b0;
        rsp_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty-table allocates, zero-size cases, address zero,
        // merges on both sides, rounding overflow and the extremes.
        pending_reqs.push_back(make_req(CMD_ALLOC, 32'hffff_ffff, 32'd0, 1'b0));
        pending_reqs.push_back(make_req(CMD_ALLOC, 32'd0, 32'hffff_ffff, 1'b1));
        pending_reqs.push_back(make_req(CMD_FREE, 32'd0, 32'h1000, 1'b0));
        pending_reqs.push_back(make_req(CMD_ALLOC, 32'd0, 32'd0, 1'b0));
        pending_reqs.push_back(make_req(CMD_ALLOC, 32'd0, 32'd1, 1'b1));
        pending_reqs.push_back(make_req(CMD_FREE, 32'h3000, 32'h1000, 1'b0));
        pending_reqs.push_back(make_req(CMD_FREE, 32'h2000, 32'h0fff, 1'b1));
        pending_reqs.push_back(make_req(CMD_FREE, 32'h0, 32'h1000, 1'b0));
        pending_reqs.push_back(make_req(CMD_FREE, 32'h8000, 32'd0, 1'b0));
        pending_reqs.push_back(make_req(CMD_FREE, 32'h8000, 32'd0, 1'b0));
        pending_reqs.push_back(make_req(CMD_FREE, 32'h7000, 32'h1000, 1'b0));
        pending_reqs.push_back(make_req(CMD_FREE, 32'hffff_f000, 32'hffff_ffff, 1'b0));
        pending_reqs.push_back(make_req(CMD_FREE, 32'h100, 32'hffff_f001, 1'b1));
        pending_reqs.push_back(make_req(CMD_ALLOC, 32'd0, 32'hffff_ffff, 1'b0));
        pending_reqs.push_back(make_req(CMD_ALLOC, 32'd0, 32'h5000, 1'b0));
        pending_reqs.push_back(make_req(CMD_ALLOC, 32'd0, 32'h1234, 1'b1));
        pending_reqs.push_back(make_req(CMD_FREE, 32'h5555_5555, 32'haaaa_aaaa, 1'b0));

        // Long receiver hold-off while the sender keeps offering.
        wait (pending_reqs.size() == 0);
        hold_off = 300;
        for (n = 0; n < 6; n++)
            pending_reqs.push_back(make_req(CMD_FREE, 32'h4000_0000 + n * 32'h10000,
                                            32'h100, 1'b0));

        for (n = 0; n < 117; n++) begin
            a = ($urandom_range(0, 7) == 0) ? $urandom() : ($urandom_range(0, 63) << 10);
            s = ($urandom_range(0, 7) == 0) ? $urandom() : ($urandom_range(0, 8) << 10);
            pending_reqs.push_back(make_req(1'($urandom_range(0, 1)), a, s,
                                            $urandom_range(0, 3) == 0));
        end

        // The table is far from full here; lost frees are only reached with
        // a filled table, which would take thousands of transactions.
        wait (pending_reqs.size() == 0 && !req_ch.valid);
        stim_done = 1;
    end

    // End of run.
    initial begin
        wait (stim_done && expected_results.size() == 0);
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/ffa_pkg.sv
rtl/ffa_req_if.sv
rtl/ffa_rsp_if.sv
rtl/ffa_ram.sv
rtl/ffa_ctrl.sv
rtl/ffa_dp.sv
rtl/first_fit_free_list_allocator_unit.sv
bench/ffa_tb_if.sv
bench/tb_top.sv
